// ===== rtl/core/rlpf_pkg.sv =====
// rlpf_pkg: shared types and constants for the rgb led pwm fader
// no dependencies
`default_nettype none
package rlpf_pkg;
    localparam int NUM_LEDS = 8;
    localparam int NCH = NUM_LEDS * 3;
    localparam int CH_W = $clog2(NCH);

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_OFF    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [0:0] CFG_PERIOD = 1'b0;
    localparam logic [0:0] CFG_SMOOTH = 1'b1;

    localparam logic [7:0] PERIOD_RESET = 8'd64;
    localparam logic [7:0] LEVEL_RESET  = 8'd10;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_DIFF   = 3'd1;
    localparam logic [2:0] OP_DIV    = 3'd2;
    localparam logic [2:0] OP_FADE   = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    typedef struct packed {
        logic [2:0]      op;
        logic [CH_W-1:0] ch;
        logic            div_start;
        logic            commit_init;
        logic            commit_done;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/rgb_led_pwm_fader.sv =====
// rgb_led_pwm_fader: top level, stream ports, output register
// depends on rlpf_pkg, rlpf_ctrl, rlpf_dp
//
// channel   dir  contents
// s_axis    in   tuser: func; tlast: frame_last; tdata: led, red, green, blue
// m_axis    out  tdata: shift_frame, pwm_position, fading
// cfg       in   0 pwm_period, 1 smooth_enable
//
// a fade step and a commit both run each of the 24 channels through the shared
// 8-bit divider, one channel at a time
// reset is synchronous and needs no clearing pass; a held result stalls intake
`default_nettype none
module rgb_led_pwm_fader import rlpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // led, red, green, blue
    input  wire logic [1:0]  s_axis_tuser,   // func
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // shift_frame, pwm_position, fading
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_smooth, w_wrap_fade, w_out_load, w_out_busy, w_take;
    logic [31:0] w_frame;
    logic [7:0] w_pos;
    logic       w_fading;
    logic       r_ovalid;
    logic [40:0] r_odata;

    assign w_take = s_axis_tvalid && s_axis_tready;

    rlpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_smooth    (w_smooth),
        .i_wrap_fade (w_wrap_fade),
        .o_cmd       (w_cmd),
        .i_status    (w_status),
        .o_out_load  (w_out_load),
        .o_out_busy  (w_out_busy),
        .i_out_free  (!r_ovalid || m_axis_tready || w_out_busy)
    );

    rlpf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_take   (w_take),
        .i_func      (s_axis_tuser),
        .i_led       (s_axis_tdata[2:0]),
        .i_red       (s_axis_tdata[10:3]),
        .i_green     (s_axis_tdata[18:11]),
        .i_blue      (s_axis_tdata[26:19]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_smooth    (w_smooth),
        .o_wrap_fade (w_wrap_fade),
        .o_frame     (w_frame),
        .o_pos       (w_pos),
        .o_fading    (w_fading)
    );

    always_ff @(posedge i_clk) begin
        if (w_out_load) r_odata <= {w_fading, w_pos, w_frame};
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_odata};
endmodule
`default_nettype wire

// ===== rtl/core/rlpf_div.sv =====
// rlpf_div: 8-bit restoring divider, one quotient bit a cycle
// depends on rlpf_pkg
`default_nettype none
module rlpf_div import rlpf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [7:0] i_num,
    input  wire logic [7:0] i_den,
    output logic            o_done,
    output logic [7:0]      o_quo,
    output logic [7:0]      o_rem
);
    logic [7:0] r_q, n_q, r_r, n_r;
    logic [3:0] r_cnt, n_cnt;
    logic       r_busy, n_busy, r_done, n_done;
    logic [8:0] w_sh;

    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_r, r_q[7]};
        if (i_start) begin
            n_q = i_num; n_r = 8'd0; n_cnt = 4'd8; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, i_den}) begin
                n_r = 8'(w_sh - {1'b0, i_den});
                n_q = {r_q[6:0], 1'b1};
            end else begin
                n_r = w_sh[7:0];
                n_q = {r_q[6:0], 1'b0};
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_r <= n_r; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ===== rtl/core/rlpf_dp.sv =====
// rlpf_dp: level stores, fade state, pwm counter and frame builder
// depends on rlpf_pkg and rlpf_div
`default_nettype none
module rlpf_dp import rlpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic        i_in_take,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_led,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_smooth,
    output logic             o_wrap_fade,
    output logic [31:0]      o_frame,
    output logic [7:0]       o_pos,
    output logic             o_fading
);
    logic [7:0] r_cur [NCH];
    logic [7:0] r_tgt [NCH];
    logic [7:0] r_step [NCH];
    logic [7:0] r_period, r_pos, r_largest, r_fcnt;
    logic       r_smooth, r_active;
    logic [7:0] w_pos_inc, w_a, w_b, w_d, w_s;
    logic       w_div_start;
    logic       w_div_done;
    logic [7:0] w_quo, w_rem;
    logic [7:0] w_fcnt_inc;

    assign w_pos_inc   = r_pos + 8'd1;
    assign o_wrap_fade = (i_in_take && i_func == FUNC_TICK && w_pos_inc >= r_period
                          && r_active && r_smooth);
    assign w_a = r_cur[i_cmd.ch];
    assign w_b = r_tgt[i_cmd.ch];
    assign w_d = (w_a > w_b) ? 8'(w_a - w_b) : 8'(w_b - w_a);
    assign w_s = r_step[i_cmd.ch];
    assign w_div_start = i_cmd.div_start;
    assign w_fcnt_inc = r_fcnt + 8'd1;

    rlpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_cmd.op == OP_FADE ? r_fcnt : r_largest),
        .i_den   (w_s),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign o_status.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET; r_smooth <= 1'b0;
            r_pos <= 8'd0; r_largest <= 8'd0; r_fcnt <= 8'd0; r_active <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_cur[i] <= LEVEL_RESET; r_tgt[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PERIOD) r_period <= i_cfg_data;
                else r_smooth <= i_cfg_data[0];
            end
            if (i_in_take) begin
                unique case (i_func)
                    FUNC_TICK: r_pos <= (w_pos_inc >= r_period) ? 8'd0 : w_pos_inc;
                    FUNC_LOAD: begin
                        if (r_smooth) begin
                            r_tgt[5'(i_led)*3]   <= i_red;
                            r_tgt[5'(i_led)*3+1] <= i_green;
                            r_tgt[5'(i_led)*3+2] <= i_blue;
                        end else begin
                            r_cur[5'(i_led)*3]   <= i_red;
                            r_cur[5'(i_led)*3+1] <= i_green;
                            r_cur[5'(i_led)*3+2] <= i_blue;
                        end
                    end
                    FUNC_OFF: begin
                        for (int i = 0; i < NCH; i++) begin
                            if (r_smooth) r_tgt[i] <= 8'd0;
                            else r_cur[i] <= 8'd0;
                        end
                    end
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                OP_DIFF: begin
                    r_step[i_cmd.ch] <= w_d;
                    // first channel of a commit restarts the maximum
                    if (i_cmd.commit_init || w_d > r_largest) r_largest <= w_d;
                end
                OP_DIV: if (w_div_done) begin
                    r_step[i_cmd.ch] <= (w_s == 8'd0) ? 8'd0 : w_quo;
                end
                OP_FADE: if (w_div_done && w_s != 8'd0 && w_rem == 8'd0) begin
                    if (w_a < w_b) r_cur[i_cmd.ch] <= w_a + 8'd1;
                    else if (w_a > w_b) r_cur[i_cmd.ch] <= w_a - 8'd1;
                end
                OP_FINISH: begin
                    if (w_fcnt_inc >= r_largest) begin
                        r_fcnt <= 8'd0; r_active <= 1'b0;
                        for (int i = 0; i < NCH; i++) r_cur[i] <= r_tgt[i];
                    end else begin
                        r_fcnt <= w_fcnt_inc;
                    end
                end
                default: ;
            endcase
            if (i_cmd.commit_done) begin
                r_fcnt <= 8'd0; r_active <= 1'b1;
            end
        end
    end

    always_comb begin
        o_frame = 32'd0;
        for (int c = 0; c < 3; c++) begin
            for (int b = 0; b < 4; b++) begin
                o_frame[4*(1+c)+b] = r_cur[(2*b+1)*3+c] > r_pos;
                o_frame[4*(4+c)+b] = r_cur[(2*b)*3+c] > r_pos;
            end
        end
    end

    assign o_smooth = r_smooth;
    assign o_pos    = r_pos;
    assign o_fading = r_active;
endmodule
`default_nettype wire

// ===== rtl/core/rlpf_ctrl.sv =====
// rlpf_ctrl: sequencer for item intake, fade commit, fade step and result hand-off
// depends on rlpf_pkg
`default_nettype none
module rlpf_ctrl import rlpf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_func,
    input  wire logic       i_last,
    input  wire logic       i_smooth,
    input  wire logic       i_wrap_fade,
    output t_cmd            o_cmd,
    input  wire t_status    i_status,
    output logic            o_out_load,
    output logic            o_out_busy,
    input  wire logic       i_out_free
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIFF = 3'd1, S_DIVS = 3'd2, S_DIVW = 3'd3,
                           S_FADES = 3'd4, S_FADEW = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
    logic [2:0]      r_st, n_st;
    logic [CH_W-1:0] r_ch, n_ch;
    logic            w_take, w_commit;

    assign o_in_ready = (r_st == S_IDLE) && i_out_free;
    assign w_take = i_in_valid && o_in_ready;
    assign w_commit = i_smooth && ((i_func == FUNC_LOAD && i_last) || i_func == FUNC_OFF);
    assign o_out_busy = 1'b0;

    always_comb begin
        n_st = r_st; n_ch = r_ch;
        o_cmd = '0; o_cmd.ch = r_ch;
        o_out_load = 1'b0;
        unique case (r_st)
            S_IDLE: if (w_take) begin
                n_ch = '0;
                if (i_func == FUNC_TICK) begin
                    n_st = i_wrap_fade ? S_FADES : S_OUT;
                end else if ((i_func == FUNC_LOAD || i_func == FUNC_OFF) && w_commit) begin
                    n_st = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                o_cmd.commit_init = (r_ch == '0);
                if (r_ch == CH_W'(NCH-1)) begin
                    n_ch = '0; n_st = S_DIVS;
                end else n_ch = r_ch + 1'b1;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1; n_st = S_DIVW;
            end
            S_DIVW: begin
                o_cmd.op = OP_DIV;
                if (i_status.div_done) begin
                    if (r_ch == CH_W'(NCH-1)) begin
                        o_cmd.commit_done = 1'b1; n_st = S_IDLE;
                    end else begin
                        n_ch = r_ch + 1'b1; n_st = S_DIVS;
                    end
                end
            end
            S_FADES: begin
                o_cmd.op = OP_FADE; o_cmd.div_start = 1'b1; n_st = S_FADEW;
            end
            S_FADEW: begin
                o_cmd.op = OP_FADE;
                if (i_status.div_done) begin
                    if (r_ch == CH_W'(NCH-1)) n_st = S_FIN;
                    else begin
                        n_ch = r_ch + 1'b1; n_st = S_FADES;
                    end
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH; n_st = S_OUT;
            end
            S_OUT: begin
                o_out_load = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
        if (!i_rst_n) r_st <= S_IDLE;
        else r_st <= n_st;
    end
endmodule
`default_nettype wire
